// File: rtl/msb_first_bit_reader_top_macros.svh
// Assertion macros for the MSB-first bit reader checker
`ifndef MSB_FIRST_BIT_READER_TOP_MACROS_SVH
`define MSB_FIRST_BIT_READER_TOP_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MFBR_CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MFBR_CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/mfbr_pkg.sv
// Shared types, opcodes and constants of the MSB-first bit reader
`default_nettype none

package mfbr_pkg;

    localparam int DEFAULT_STORE_DEPTH = 256;
    localparam int MIN_MSG_LENGTH      = 2;
    localparam int POS_W               = 9;
    localparam int VALUE_W             = 16;
    localparam int BYTE_W              = 8;
    localparam int BIT_POS_W           = 3;
    localparam int COUNT_W             = 4;
    localparam int FIELD_MAX_BITS      = 8;

    localparam logic [COUNT_W-1:0] OP_BEGIN  = 4'd0;
    localparam logic [COUNT_W-1:0] OP_LOAD   = 4'd1;
    localparam logic [COUNT_W-1:0] OP_END    = 4'd2;
    localparam logic [COUNT_W-1:0] OP_BITS   = 4'd3;
    localparam logic [COUNT_W-1:0] OP_BYTE   = 4'd4;
    localparam logic [COUNT_W-1:0] OP_WORD   = 4'd5;
    localparam logic [COUNT_W-1:0] OP_PEEK   = 4'd6;
    localparam logic [COUNT_W-1:0] OP_PEEKAT = 4'd7;
    localparam logic [COUNT_W-1:0] OP_SEEK   = 4'd8;
    localparam logic [COUNT_W-1:0] OP_FWD    = 4'd9;
    localparam logic [COUNT_W-1:0] OP_BACK   = 4'd10;
    localparam logic [COUNT_W-1:0] OP_SKIP   = 4'd11;

    typedef struct packed {
        logic [COUNT_W-1:0] opcode;
        logic [BYTE_W-1:0]  load_byte;
        logic [COUNT_W-1:0] bit_count;
        logic [POS_W-1:0]   amount;
        logic [POS_W-1:0]   position;
    } req_t;

    typedef struct packed {
        logic                 ok;
        logic [VALUE_W-1:0]   value;
        logic [POS_W-1:0]     old_position;
        logic [POS_W-1:0]     byte_index;
        logic [BIT_POS_W-1:0] bit_offset;
        logic [POS_W-1:0]     stored_length;
        logic                 is_empty;
    } rsp_t;

    typedef struct packed {
        logic accept;
        logic fetch_first;
        logic fetch_second;
        logic execute;
    } cmd_t;

    typedef struct packed {
        logic mem_read;
    } status_t;

endpackage

`default_nettype wire

// File: rtl/mfbr_ctrl.sv
// Controller state machine of the MSB-first bit reader
`default_nettype none

module mfbr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mfbr_pkg::status_t status,
    output mfbr_pkg::cmd_t         cmd,
    output logic                   busy,
    output logic                   done
);
    import mfbr_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       done_reg;
    logic       accept;

    assign accept = start && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = status.mem_read ? S_FETCH : S_EXEC;
                end
            end
            S_FETCH: state_next = S_EXEC;
            S_EXEC:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_EXEC);
        end
    end

    assign cmd.accept       = accept;
    assign cmd.fetch_first  = accept && status.mem_read;
    assign cmd.fetch_second = (state_reg == S_FETCH);
    assign cmd.execute      = (state_reg == S_EXEC);
    assign busy             = (state_reg != S_IDLE);
    assign done             = done_reg;

endmodule

`default_nettype wire

// File: rtl/mfbr_dp.sv
// Datapath of the MSB-first bit reader: byte store, positions and result
`default_nettype none

module mfbr_dp #(
    parameter int STORE_DEPTH = mfbr_pkg::DEFAULT_STORE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mfbr_pkg::req_t  req,
    input  wire mfbr_pkg::cmd_t  cmd,
    output mfbr_pkg::status_t    status,
    output mfbr_pkg::rsp_t       rsp
);
    import mfbr_pkg::*;

    localparam int LEN_W  = $clog2(STORE_DEPTH + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int CMP_W  = ((LEN_W > POS_W) ? LEN_W : POS_W) + 1;

    logic [BYTE_W-1:0] mem [STORE_DEPTH];

    logic [LEN_W-1:0]     ri_reg;
    logic [LEN_W-1:0]     ri_next;
    logic [BIT_POS_W-1:0] bp_reg;
    logic [BIT_POS_W-1:0] bp_next;
    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic                 empty_reg;
    logic                 empty_next;
    logic                 ovf_reg;
    logic                 ovf_next;

    req_t              req_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic [BYTE_W-1:0] b0_reg;
    logic [BYTE_W-1:0] b1_reg;

    logic [CMP_W-1:0]  ri_ext;
    logic [CMP_W-1:0]  ri_p1;
    logic [CMP_W-1:0]  ri_p2;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  len_eff;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  amt_ext;
    logic [CMP_W-1:0]  fwd_sum;
    logic [CMP_W-1:0]  in_pos_ext;
    logic [ADDR_W-1:0] rd_addr;
    logic              mem_we;
    logic              ok;
    logic [VALUE_W-1:0] val;

    logic [COUNT_W-1:0] field_n;
    logic [4:0]         field_sum;
    logic               field_cross;
    logic               field_ok;
    logic [VALUE_W-1:0] field_pair;
    logic [VALUE_W-1:0] field_val;
    logic [CMP_W-1:0]   field_ri;

    assign status.mem_read = (req.opcode == OP_BITS) || (req.opcode == OP_BYTE) ||
                             (req.opcode == OP_WORD) || (req.opcode == OP_PEEK) ||
                             (req.opcode == OP_PEEKAT);

    assign ri_ext     = CMP_W'(ri_reg);
    assign ri_p1      = ri_ext + CMP_W'(1);
    assign ri_p2      = ri_ext + CMP_W'(2);
    assign len_ext    = CMP_W'(len_reg);
    assign len_eff    = empty_reg ? '0 : len_ext;
    assign pos_ext    = CMP_W'(req_reg.position);
    assign amt_ext    = CMP_W'(req_reg.amount);
    assign fwd_sum    = ri_ext + amt_ext;
    assign in_pos_ext = CMP_W'(req.position);

    always_comb
    begin
        if (cmd.fetch_first)
        begin
            rd_addr = (req.opcode == OP_PEEKAT) ? in_pos_ext[ADDR_W-1:0]
                                                : ri_ext[ADDR_W-1:0];
        end
        else
        begin
            rd_addr = ri_p1[ADDR_W-1:0];
        end
    end

    assign field_n     = (req_reg.opcode == OP_BYTE) ? COUNT_W'(FIELD_MAX_BITS)
                                                     : req_reg.bit_count;
    assign field_sum   = 5'(bp_reg) + 5'(field_n);
    assign field_cross = field_sum > 5'(FIELD_MAX_BITS);
    assign field_ok    = !empty_reg && (field_n != '0) &&
                         (field_n <= COUNT_W'(FIELD_MAX_BITS)) &&
                         (field_cross ? (ri_p1 < len_ext) : (ri_ext < len_ext));
    assign field_pair  = {b0_reg, b1_reg} << bp_reg;
    assign field_val   = field_pair >> (5'd16 - 5'(field_n));
    assign field_ri    = field_sum[3] ? ri_p1 : ri_ext;

    always_comb
    begin
        ri_next    = ri_reg;
        bp_next    = bp_reg;
        len_next   = len_reg;
        empty_next = empty_reg;
        ovf_next   = ovf_reg;
        mem_we     = 1'b0;
        ok         = 1'b0;
        val        = '0;
        unique case (req_reg.opcode)
            OP_BEGIN:
            begin
                ri_next    = '0;
                bp_next    = '0;
                len_next   = '0;
                empty_next = 1'b1;
                ovf_next   = 1'b0;
                ok         = 1'b1;
            end
            OP_LOAD:
            begin
                if (empty_reg)
                begin
                    if (len_ext < CMP_W'(STORE_DEPTH))
                    begin
                        mem_we   = 1'b1;
                        len_next = LEN_W'(len_ext + CMP_W'(1));
                        ok       = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
            end
            OP_END:
            begin
                ri_next = '0;
                bp_next = '0;
                if (!ovf_reg && (len_ext >= CMP_W'(MIN_MSG_LENGTH)) &&
                    (len_ext <= CMP_W'(STORE_DEPTH)))
                begin
                    empty_next = 1'b0;
                    ok         = 1'b1;
                end
                else
                begin
                    len_next   = '0;
                    empty_next = 1'b1;
                end
            end
            OP_BITS:
            begin
                if (field_ok)
                begin
                    val     = field_val;
                    ri_next = LEN_W'(field_ri);
                    bp_next = field_sum[BIT_POS_W-1:0];
                    ok      = 1'b1;
                end
            end
            OP_BYTE:
            begin
                if (bp_reg != '0)
                begin
                    if (field_ok)
                    begin
                        val     = field_val;
                        ri_next = LEN_W'(field_ri);
                        bp_next = field_sum[BIT_POS_W-1:0];
                        ok      = 1'b1;
                    end
                end
                else if (!empty_reg && (ri_ext < len_ext))
                begin
                    val     = VALUE_W'(b0_reg);
                    ri_next = LEN_W'(ri_p1);
                    ok      = 1'b1;
                end
            end
            OP_WORD:
            begin
                if (!empty_reg && (bp_reg == '0) && (ri_p1 < len_ext))
                begin
                    val     = {b0_reg, b1_reg};
                    ri_next = LEN_W'(ri_p2);
                    ok      = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (!empty_reg && (ri_ext < len_ext))
                begin
                    val = VALUE_W'(b0_reg);
                    ok  = 1'b1;
                end
            end
            OP_PEEKAT:
            begin
                if (!empty_reg && (pos_ext < len_ext))
                begin
                    val = VALUE_W'(b0_reg);
                    ok  = 1'b1;
                end
            end
            OP_SEEK:
            begin
                if ((bp_reg == '0) && (pos_ext <= len_eff))
                begin
                    ri_next = LEN_W'(pos_ext);
                    ok      = 1'b1;
                end
            end
            OP_FWD:
            begin
                if ((bp_reg == '0) && (fwd_sum <= len_eff))
                begin
                    ri_next = LEN_W'(fwd_sum);
                    ok      = 1'b1;
                end
            end
            OP_BACK:
            begin
                if ((bp_reg == '0) && (ri_ext >= amt_ext))
                begin
                    ri_next = LEN_W'(ri_ext - amt_ext);
                    ok      = 1'b1;
                end
            end
            OP_SKIP:
            begin
                if (bp_reg != '0)
                begin
                    ri_next = LEN_W'(ri_p1);
                    bp_next = '0;
                end
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_next.ok            = ok;
        rsp_next.value         = val;
        rsp_next.old_position  = ri_ext[POS_W-1:0];
        rsp_next.byte_index    = CMP_W'(ri_next) >> 0 == '0 ? '0 : POS_W'(ri_next);
        rsp_next.bit_offset    = bp_next;
        rsp_next.stored_length = POS_W'(len_next);
        rsp_next.is_empty      = empty_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ri_reg    <= '0;
            bp_reg    <= '0;
            len_reg   <= '0;
            empty_reg <= 1'b1;
            ovf_reg   <= 1'b0;
        end
        else if (cmd.execute)
        begin
            ri_reg    <= ri_next;
            bp_reg    <= bp_next;
            len_reg   <= len_next;
            empty_reg <= empty_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
        end
        if (cmd.execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && mem_we)
        begin
            mem[len_reg[ADDR_W-1:0]] <= req_reg.load_byte;
        end
        if (cmd.fetch_first)
        begin
            b0_reg <= mem[rd_addr];
        end
        if (cmd.fetch_second)
        begin
            b1_reg <= mem[rd_addr];
        end
    end

    assign rsp = rsp_reg;

endmodule

`default_nettype wire

// File: rtl/msb_first_bit_reader_top.sv
// Top level of the MSB-first bit reader
//
// One request is taken at a rising edge with start high and busy low; its
// single result appears on rsp with done high for exactly one cycle, and the
// receiver cannot stall it. Requests that read the byte store (bits, byte,
// word, peek, peekat) pass through a fetch state before the execute state,
// the others go straight to execute, since the store has one read port and
// a word or a field that crosses a byte boundary needs two bytes fetched one
// after the other. busy drops in the cycle that done shows, so a new request
// may be taken there. A store entry is defined only once a load has written it.
`default_nettype none

module msb_first_bit_reader_top #(
    parameter int STORE_DEPTH = mfbr_pkg::DEFAULT_STORE_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire mfbr_pkg::req_t req,
    output logic                busy,
    output logic                done,
    output mfbr_pkg::rsp_t      rsp
);
    import mfbr_pkg::*;

    cmd_t    cmd;
    status_t status;

    mfbr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    mfbr_dp #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .cmd    (cmd),
        .status (status),
        .rsp    (rsp)
    );

endmodule

`default_nettype wire

// File: rtl/msb_first_bit_reader_top_chk.sv
// Port-level checker of the MSB-first bit reader, bound to the top level
`default_nettype none

`include "msb_first_bit_reader_top_macros.svh"

module msb_first_bit_reader_top_chk (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           done,
    input wire mfbr_pkg::rsp_t rsp
);
    import mfbr_pkg::*;

    `MFBR_CHK_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `MFBR_CHK_IMPLY(a_done_idle, done, !busy, "result shown while still busy")
    `MFBR_CHK_IMPLY(a_done_after_busy, done, $past(busy), "result without a request in work")
    `MFBR_CHK_IMPLY(a_refused_zero, done && !rsp.ok, rsp.value == '0, "refused request with value")
    `MFBR_CHK_IMPLY(a_empty_home, done && rsp.is_empty,
        (rsp.byte_index == '0) && (rsp.bit_offset == '0), "empty store with nonzero position")

endmodule

bind msb_first_bit_reader_top msb_first_bit_reader_top_chk u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

`default_nettype wire

// File: bench/tb_top.sv
// Self-checking testbench for the MSB-first bit reader: directed and random requests
module tb_top;
    import mfbr_pkg::*;

    localparam int STORE_DEPTH = 256;

    logic clk;
    logic rst_n;
    logic start;
    req_t req;
    logic busy;
    logic done;
    rsp_t rsp;

    rsp_t pending_results[$];
    int   fail_count;
    int   idle_pct;

    logic [7:0]  store_img [0:STORE_DEPTH-1];
    int unsigned rd_idx;
    int unsigned bit_ofs;
    int unsigned msg_len;
    bit          empty_f;
    bit          ovf_f;

    msb_first_bit_reader_top #(.STORE_DEPTH(STORE_DEPTH)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .busy  (busy),
        .done  (done),
        .rsp   (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

    function automatic bit take_field(int unsigned n, output int unsigned v);
        int unsigned hi;
        v = 0;
        if (empty_f || n == 0 || n > FIELD_MAX_BITS)
            return 1'b0;
        if (bit_ofs + n <= 8)
        begin
            if (rd_idx >= msg_len)
                return 1'b0;
            hi = (int'(store_img[rd_idx]) << bit_ofs) & 32'hFF;
            v = hi >> (8 - n);
            bit_ofs += n;
            if (bit_ofs == 8)
            begin
                bit_ofs = 0;
                rd_idx++;
            end
        end
        else
        begin
            if (rd_idx + 1 >= msg_len)
                return 1'b0;
            hi = (int'(store_img[rd_idx]) << bit_ofs) & 32'hFF;
            rd_idx++;
            bit_ofs = bit_ofs + n - 8;
            v = ((hi >> (8 - n)) | (int'(store_img[rd_idx]) >> (8 - bit_ofs))) & 32'hFF;
        end
        return 1'b1;
    endfunction

    function automatic rsp_t predict_reader_result(req_t r);
        rsp_t        res;
        int unsigned prior;
        int unsigned len_eff;
        int unsigned v;
        int unsigned amt;
        int unsigned pos;
        bit          ok;
        prior   = rd_idx;
        len_eff = empty_f ? 0 : msg_len;
        v       = 0;
        ok      = 1'b0;
        amt     = r.amount;
        pos     = r.position;
        case (r.opcode)
            OP_BEGIN:
            begin
                rd_idx  = 0;
                bit_ofs = 0;
                msg_len = 0;
                empty_f = 1'b1;
                ovf_f   = 1'b0;
                ok      = 1'b1;
            end
            OP_LOAD:
            begin
                if (empty_f)
                begin
                    if (msg_len < STORE_DEPTH)
                    begin
                        store_img[msg_len] = r.load_byte;
                        msg_len++;
                        ok = 1'b1;
                    end
                    else
                        ovf_f = 1'b1;
                end
            end
            OP_END:
            begin
                rd_idx  = 0;
                bit_ofs = 0;
                if (!ovf_f && msg_len >= MIN_MSG_LENGTH && msg_len <= STORE_DEPTH)
                begin
                    empty_f = 1'b0;
                    ok      = 1'b1;
                end
                else
                begin
                    msg_len = 0;
                    empty_f = 1'b1;
                end
            end
            OP_BITS:
                ok = take_field(r.bit_count, v);
            OP_BYTE:
            begin
                if (!empty_f)
                begin
                    if (bit_ofs != 0)
                        ok = take_field(8, v);
                    else if (rd_idx < msg_len)
                    begin
                        v = store_img[rd_idx];
                        rd_idx++;
                        ok = 1'b1;
                    end
                end
            end
            OP_WORD:
            begin
                if (!empty_f && bit_ofs == 0 && rd_idx + 1 < msg_len)
                begin
                    v = (int'(store_img[rd_idx]) << 8) | int'(store_img[rd_idx + 1]);
                    rd_idx += 2;
                    ok = 1'b1;
                end
            end
            OP_PEEK:
            begin
                if (!empty_f && rd_idx < msg_len)
                begin
                    v  = store_img[rd_idx];
                    ok = 1'b1;
                end
            end
            OP_PEEKAT:
            begin
                if (!empty_f && pos < msg_len)
                begin
                    v  = store_img[pos];
                    ok = 1'b1;
                end
            end
            OP_SEEK:
            begin
                if (bit_ofs == 0 && pos <= len_eff)
                begin
                    rd_idx = pos;
                    ok     = 1'b1;
                end
            end
            OP_FWD:
            begin
                if (bit_ofs == 0 && rd_idx + amt <= len_eff)
                begin
                    rd_idx += amt;
                    ok = 1'b1;
                end
            end
            OP_BACK:
            begin
                if (bit_ofs == 0 && rd_idx >= amt)
                begin
                    rd_idx -= amt;
                    ok = 1'b1;
                end
            end
            OP_SKIP:
            begin
                if (bit_ofs != 0)
                begin
                    rd_idx++;
                    bit_ofs = 0;
                end
                ok = 1'b1;
            end
            default:
                ok = 1'b0;
        endcase
        res.ok            = ok;
        res.value         = v[VALUE_W-1:0];
        res.old_position  = prior[POS_W-1:0];
        res.byte_index    = rd_idx[POS_W-1:0];
        res.bit_offset    = bit_ofs[BIT_POS_W-1:0];
        res.stored_length = msg_len[POS_W-1:0];
        res.is_empty      = empty_f;
        return res;
    endfunction

    function automatic req_t mk(logic [COUNT_W-1:0] op, int lb, int cnt, int amt, int pos);
        req_t r;
        r.opcode    = op;
        r.load_byte = lb[BYTE_W-1:0];
        r.bit_count = cnt[COUNT_W-1:0];
        r.amount    = amt[POS_W-1:0];
        r.position  = pos[POS_W-1:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("ok", want.ok, rsp.ok);
                check_field("value", want.value, rsp.value);
                check_field("old_position", want.old_position, rsp.old_position);
                check_field("byte_index", want.byte_index, rsp.byte_index);
                check_field("bit_offset", want.bit_offset, rsp.bit_offset);
                check_field("stored_length", want.stored_length, rsp.stored_length);
                check_field("is_empty", want.is_empty, rsp.is_empty);
            end
        end
    end

    // enter and leave at a falling edge; start stays high for a back-to-back request
    task automatic send_item(req_t r);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_reader_result(r));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic test_moves_after_reset();
        send_item(mk(OP_SEEK, 0, 0, 0, 0));
        send_item(mk(OP_SEEK, 0, 0, 0, 1));
        send_item(mk(OP_FWD, 0, 0, 0, 0));
        send_item(mk(OP_FWD, 0, 0, 1, 0));
        send_item(mk(OP_BACK, 0, 0, 0, 0));
        send_item(mk(OP_BACK, 0, 0, 1, 0));
        send_item(mk(OP_SKIP, 0, 0, 0, 0));
        send_item(mk(4'd15, 8'hFF, 15, 511, 511));
        send_item(mk(OP_END, 0, 0, 0, 0));
    endtask

    // write every store entry so that later reads never see an unwritten one
    task automatic test_full_store();
        send_item(mk(OP_BEGIN, 0, 0, 0, 0));
        for (int i = 0; i < STORE_DEPTH; i++)
            send_item(mk(OP_LOAD, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : $urandom_range(0, 255),
                         0, 0, 0));
        send_item(mk(OP_END, 0, 0, 0, 0));
        send_item(mk(OP_SEEK, 0, 0, 0, STORE_DEPTH));
        send_item(mk(OP_PEEKAT, 0, 0, 0, STORE_DEPTH - 1));
        send_item(mk(OP_PEEKAT, 0, 0, 0, STORE_DEPTH));
        send_item(mk(OP_BACK, 0, 0, STORE_DEPTH, 0));
        send_item(mk(OP_FWD, 0, 0, STORE_DEPTH, 0));
        send_item(mk(OP_BEGIN, 0, 0, 0, 0));
        for (int i = 0; i <= STORE_DEPTH; i++)
            send_item(mk(OP_LOAD, $urandom_range(0, 255), 0, 0, 0));
        send_item(mk(OP_END, 0, 0, 0, 0));
        send_item(mk(OP_BEGIN, 0, 0, 0, 0));
        send_item(mk(OP_LOAD, 8'h5A, 0, 0, 0));
        send_item(mk(OP_END, 0, 0, 0, 0));
    endtask

    task automatic test_field_reads();
        send_item(mk(OP_BEGIN, 0, 0, 0, 0));
        send_item(mk(OP_LOAD, 8'hA5, 0, 0, 0));
        send_item(mk(OP_LOAD, 8'hFF, 0, 0, 0));
        send_item(mk(OP_LOAD, 8'h00, 0, 0, 0));
        send_item(mk(OP_LOAD, 8'h3C, 0, 0, 0));
        send_item(mk(OP_LOAD, 8'h81, 0, 0, 0));
        send_item(mk(OP_END, 0, 0, 0, 0));
        send_item(mk(OP_LOAD, 8'h77, 0, 0, 0));
        send_item(mk(OP_BITS, 0, 0, 0, 0));
        send_item(mk(OP_BITS, 0, 9, 0, 0));
        send_item(mk(OP_BITS, 0, 15, 0, 0));
        send_item(mk(OP_BITS, 0, 1, 0, 0));
        send_item(mk(OP_BITS, 0, 3, 0, 0));
        send_item(mk(OP_WORD, 0, 0, 0, 0));
        send_item(mk(OP_SEEK, 0, 0, 0, 0));
        send_item(mk(OP_FWD, 0, 0, 0, 0));
        send_item(mk(OP_BACK, 0, 0, 0, 0));
        send_item(mk(OP_BYTE, 0, 0, 0, 0));
        send_item(mk(OP_BITS, 0, 8, 0, 0));
        send_item(mk(OP_SKIP, 0, 0, 0, 0));
        send_item(mk(OP_SKIP, 0, 0, 0, 0));
        send_item(mk(OP_PEEK, 0, 0, 0, 0));
        send_item(mk(OP_PEEKAT, 0, 0, 0, 4));
        send_item(mk(OP_PEEKAT, 0, 0, 0, 5));
        send_item(mk(OP_PEEKAT, 0, 0, 0, 511));
        send_item(mk(OP_SEEK, 0, 0, 0, 0));
        send_item(mk(OP_WORD, 0, 0, 0, 0));
        send_item(mk(OP_BYTE, 0, 0, 0, 0));
        send_item(mk(OP_SEEK, 0, 0, 0, 5));
        send_item(mk(OP_SEEK, 0, 0, 0, 6));
        send_item(mk(OP_BYTE, 0, 0, 0, 0));
        send_item(mk(OP_WORD, 0, 0, 0, 0));
        send_item(mk(OP_PEEK, 0, 0, 0, 0));
        send_item(mk(OP_BITS, 0, 1, 0, 0));
        send_item(mk(OP_BACK, 0, 0, 256, 0));
        send_item(mk(OP_BACK, 0, 0, 5, 0));
        send_item(mk(OP_FWD, 0, 0, 256, 0));
        send_item(mk(OP_FWD, 0, 0, 4, 0));
        send_item(mk(OP_WORD, 0, 0, 0, 0));
        send_item(mk(OP_BITS, 0, 4, 0, 0));
        send_item(mk(OP_BITS, 0, 8, 0, 0));
        send_item(mk(OP_BITS, 0, 4, 0, 0));
    endtask

    task automatic test_empty_reads();
        send_item(mk(OP_BEGIN, 0, 0, 0, 0));
        send_item(mk(OP_BITS, 0, 1, 0, 0));
        send_item(mk(OP_BYTE, 0, 0, 0, 0));
        send_item(mk(OP_WORD, 0, 0, 0, 0));
        send_item(mk(OP_PEEK, 0, 0, 0, 0));
        send_item(mk(OP_PEEKAT, 0, 0, 0, 0));
        for (int op = 12; op < 16; op++)
            send_item(mk(op[COUNT_W-1:0], 0, 0, 0, 0));
    endtask

    function automatic req_t random_query();
        int pick;
        int amt;
        int pos;
        pick = $urandom_range(0, 99);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: amt = $urandom_range(0, 4);
            7, 8:                amt = $urandom_range(0, msg_len + 1);
            default:             amt = $urandom_range(0, 511);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: pos = $urandom_range(0, (msg_len > 0) ? msg_len - 1 : 0);
            6, 7, 8:          pos = $urandom_range(0, msg_len + 2);
            default:          pos = $urandom_range(0, 511);
        endcase
        if (pick < 30)
            return mk(OP_BITS, $urandom_range(0, 255),
                      ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(0, 15),
                      amt, pos);
        else if (pick < 45)
            return mk(OP_BYTE, $urandom_range(0, 255), $urandom_range(0, 15), amt, pos);
        else if (pick < 55)
            return mk(OP_WORD, $urandom_range(0, 255), $urandom_range(0, 15), amt, pos);
        else if (pick < 62)
            return mk(OP_PEEK, $urandom_range(0, 255), $urandom_range(0, 15), amt, pos);
        else if (pick < 70)
            return mk(OP_PEEKAT, $urandom_range(0, 255), $urandom_range(0, 15), amt, pos);
        else if (pick < 76)
            return mk(OP_SEEK, $urandom_range(0, 255), $urandom_range(0, 15), amt, pos);
        else if (pick < 82)
            return mk(OP_FWD, $urandom_range(0, 255), $urandom_range(0, 15), amt, pos);
        else if (pick < 88)
            return mk(OP_BACK, $urandom_range(0, 255), $urandom_range(0, 15), amt, pos);
        else if (pick < 97)
            return mk(OP_SKIP, $urandom_range(0, 255), $urandom_range(0, 15), amt, pos);
        return mk(COUNT_W'($urandom_range(0, 15)), $urandom_range(0, 255),
                  $urandom_range(0, 15), $urandom_range(0, 511), $urandom_range(0, 511));
    endfunction

    // mostly well-formed messages with random content, followed by a burst of reads
    task automatic test_random_messages(int pct, int target);
        int sent;
        int len;
        int reads;
        int sel;
        idle_pct = pct;
        sent     = 0;
        while (sent < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 85)
                len = $urandom_range(2, 16);
            else if (sel < 91)
                len = $urandom_range(17, STORE_DEPTH);
            else if (sel < 97)
                len = $urandom_range(0, 1);
            else
                len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 3);
            if ($urandom_range(0, 9) != 0)
            begin
                send_item(mk(OP_BEGIN, $urandom_range(0, 255), $urandom_range(0, 15),
                             $urandom_range(0, 511), $urandom_range(0, 511)));
                sent++;
            end
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 49) == 0)
                    send_item(random_query());
                else
                    send_item(mk(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 15),
                                 $urandom_range(0, 511), $urandom_range(0, 511)));
            end
            sent += len;
            if ($urandom_range(0, 19) != 0)
            begin
                send_item(mk(OP_END, $urandom_range(0, 255), $urandom_range(0, 15),
                             $urandom_range(0, 511), $urandom_range(0, 511)));
                sent++;
            end
            reads = $urandom_range(5, 30);
            for (int i = 0; i < reads; i++)
                send_item(random_query());
            sent += reads;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        start      = 1'b0;
        req        = '0;
        idle_pct   = 0;
        fail_count = 0;
        rd_idx     = 0;
        bit_ofs    = 0;
        msg_len    = 0;
        empty_f    = 1'b1;
        ovf_f      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_moves_after_reset();
        test_full_store();
        test_field_reads();
        test_empty_reads();
        wait_idle();
        test_random_messages(0, 300);
        test_random_messages(58, 300);
        wait_idle();
        test_random_messages(0, 250);
        test_random_messages(15, 250);
        wait_idle();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
